/* rtl/bas_pkg.sv */
// Package for the batch ascending sorter.
// Holds the shared element width, the default batch size and the controller/datapath command and status types.
// No dependencies.
package bas_pkg;

  // width of one element, two's complement
  localparam int unsigned DATA_W = 32;

  // default number of elements in one batch
  localparam int unsigned BATCH_SIZE_DEF = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_we;    // write the incoming beat into the store
    logic rd_en;      // read one store entry for the minimum search
    logic rd_first;   // that read opens a new pass
    logic emit;       // hand the minimum to the output, write the swap back
    logic emit_last;  // the emitted beat closes the batch
  } bas_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
  } bas_status_t;

endpackage

/* rtl/bas_in_if.sv */
// Input channel of the batch ascending sorter: one unsorted element per beat.
// Depends on bas_pkg for the element width.
interface bas_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [bas_pkg::DATA_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/bas_out_if.sv */
// Output channel of the batch ascending sorter: one sorted element per beat.
// Depends on bas_pkg for the element width.
interface bas_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bas_pkg::DATA_W-1:0]  sorted_value;
  logic                               final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

/* rtl/bas_datapath.sv */
// Datapath of the batch ascending sorter: element store, minimum search,
// swap write-back and output register. Depends on bas_pkg.
module bas_datapath #(
  parameter int unsigned BATCH_SIZE = bas_pkg::BATCH_SIZE_DEF,
  localparam int unsigned IDX_W     = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bas_pkg::bas_cmd_t                  cmd_i,
  input  logic [IDX_W-1:0]                   addr_i,
  input  logic signed [bas_pkg::DATA_W-1:0]  in_value_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [bas_pkg::DATA_W-1:0]  sorted_value_o,
  output logic                               final_res_o,
  output bas_pkg::bas_status_t               status_o
);
  import bas_pkg::*;

  logic signed [DATA_W-1:0] store_q [BATCH_SIZE];
  logic signed [DATA_W-1:0] rdata_q;
  logic                     rd_vld_q;
  logic                     rd_first_q;
  logic [IDX_W-1:0]         rd_idx_q;

  logic signed [DATA_W-1:0] min_q;
  logic [IDX_W-1:0]         min_idx_q;
  logic signed [DATA_W-1:0] head_q;   // entry at the head of the current pass

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_last_q;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  // single write port: loading beats or the swap of a finished pass
  assign wr_en   = cmd_i.load_we | cmd_i.emit;
  assign wr_addr = cmd_i.emit ? min_idx_q : addr_i;
  assign wr_data = cmd_i.emit ? head_q : in_value_i;

  // element store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_q[addr_i];
    end
  end

  // read tag travelling with the registered data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_idx_q   <= addr_i;
      rd_first_q <= cmd_i.rd_first;
    end
  end

  // running minimum of the pass, head entry kept for the swap
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (rd_first_q || (rdata_q < min_q)) begin
        min_q     <= rdata_q;
        min_idx_q <= rd_idx_q;
      end
      if (rd_first_q) begin
        head_q <= rdata_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= min_q;
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sorted_value_o    = out_value_q;
  assign final_res_o       = out_last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // the minimum of a pass always sits at an earlier index than a later read
  a_min_idx_behind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q && !rd_first_q |-> rd_idx_q > min_idx_q)
    else $error("minimum index not behind scan index");

  // no compare still in flight when a pass hands over its minimum
  a_emit_settled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !rd_vld_q)
    else $error("emit while a compare is pending");

  // an emitted beat shows up on the output
  a_emit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted beat not presented");

endmodule

/* rtl/bas_controller.sv */
// Controller of the batch ascending sorter: load, scan and emit sequencing
// with fill, pass and scan counters. Depends on bas_pkg.
module bas_controller #(
  parameter int unsigned BATCH_SIZE = bas_pkg::BATCH_SIZE_DEF,
  localparam int unsigned IDX_W     = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bas_pkg::bas_status_t  status_i,
  output bas_pkg::bas_cmd_t     cmd_o,
  output logic [IDX_W-1:0]      addr_o
);
  import bas_pkg::*;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BATCH_SIZE - 1);

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] pass_q, pass_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic             in_beat;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_beat    = in_ready_o && in_valid_i;
  assign addr_o     = (state_q == S_LOAD) ? fill_q : scan_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    pass_d  = pass_q;
    scan_d  = scan_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_beat) begin
          cmd_o.load_we = 1'b1;
          if (fill_q == LAST_IDX) begin
            fill_d  = '0;
            pass_d  = '0;
            scan_d  = '0;
            state_d = S_SCAN;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (scan_q == pass_q);
        if (scan_q == LAST_IDX) begin
          state_d = S_WAIT;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_WAIT: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = (pass_q == LAST_IDX);
          if (pass_q == LAST_IDX) begin
            state_d = S_LOAD;
          end else begin
            pass_d  = pass_q + 1'b1;
            scan_d  = pass_q + 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fill_q  <= '0;
      pass_q  <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pass_q  <= pass_d;
      scan_q  <= scan_d;
    end
  end

  // a beat is only handed over when the output register has room
  a_emit_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("emit without room in the output register");

  // the closing beat of a batch returns the block to loading
  a_last_to_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.emit_last |=> state_q == S_LOAD && fill_q == '0)
    else $error("batch end did not return to loading");

  // store write port never claimed twice
  a_one_writer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_we && cmd_o.emit))
    else $error("load and swap write in the same cycle");

endmodule

/* rtl/batch_ascending_sorter_top.sv */
// Batch ascending sorter: takes BATCH_SIZE signed 32-bit elements, one per
// input beat at one beat per cycle while loading, then sorts them by selection
// sort and sends them out smallest first, with final_res set on the largest.
// The sorting pace is set by the single read port of the element store, which
// the minimum search walks one entry per cycle, with a wait state per pass for
// the registered read and an emit state for the swap write. Output stalls
// hold the emit state. No input beat is taken while a batch is being sorted;
// the next batch may load while the last sorted beat waits.
// Depends on bas_pkg, bas_in_if, bas_out_if, bas_controller, bas_datapath.
module batch_ascending_sorter_top #(
  parameter int unsigned BATCH_SIZE = bas_pkg::BATCH_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bas_in_if.sink     in_i,
  bas_out_if.source  out_o
);
  import bas_pkg::*;

  localparam int unsigned IDX_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

  bas_cmd_t         cmd;
  bas_status_t      status;
  logic [IDX_W-1:0] addr;
  logic             in_ready;

  assign in_i.ready = in_ready;

  // sequencing
  bas_controller #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  // store, minimum search and output register
  bas_datapath #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .addr_i         (addr),
    .in_value_i     (in_i.value),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .sorted_value_o (out_o.sorted_value),
    .final_res_o    (out_o.final_res),
    .status_o       (status)
  );

endmodule

/* verif/batch_ascending_sorter_top_test.sv */
`timescale 1ns / 1ps
// Testbench for batch_ascending_sorter_top: feeds batches of signed elements,
// predicts each sorted batch and checks every output beat against it.
// Depends on bas_pkg, bas_in_if, bas_out_if and the sorter RTL.
module batch_ascending_sorter_top_test;
  import bas_pkg::*;

  localparam int unsigned BATCH   = BATCH_SIZE_DEF;
  // load plus sort cycles of one batch
  localparam int unsigned SORT_LAT = BATCH + BATCH * (BATCH + 1) / 2 + 2 * BATCH;
  localparam int unsigned RANDOM_ELEMS = 359;

  localparam logic signed [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
  } sorted_beat_t;

  // shapes of random batch content
  typedef enum logic [2:0] {
    FILL_ANY,
    FILL_NARROW,
    FILL_EXTREME,
    FILL_RISING,
    FILL_FALLING
  } batch_fill_e;

  logic clk_i;
  logic rst_ni;

  bas_in_if  in_if ();
  bas_out_if out_if ();

  batch_ascending_sorter_top #(
    .BATCH_SIZE (BATCH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // batch being collected and sorted beats still owed by the block
  logic signed [DATA_W-1:0] batch_buf [BATCH];
  int unsigned              batch_fill;
  sorted_beat_t             owed_beats [$];
  int unsigned              mismatch_count;
  bit                       send_burst;
  bit                       recv_burst;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // collect one element; a full batch is sorted and queued as owed beats
  function automatic void absorb_element(logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] ordered [BATCH];
    logic signed [DATA_W-1:0] key;
    int                       j;
    sorted_beat_t             beat;
    batch_buf[batch_fill] = v;
    batch_fill++;
    if (batch_fill < BATCH) return;
    // insertion sort, ascending signed
    for (int i = 0; i < BATCH; i++) begin
      key = batch_buf[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    for (int i = 0; i < BATCH; i++) begin
      beat.sorted_value = ordered[i];
      beat.final_res    = (i == BATCH - 1);
      owed_beats.push_back(beat);
    end
    batch_fill = 0;
  endfunction

  // send one element, with a random gap before it unless bursting
  task automatic send_element(logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_element(v);
  endtask

  // hold the input quiet until every owed beat has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed_beats.size() != 0);
  endtask

  // output sink: random stall before each beat
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // compare each accepted output beat with the oldest owed beat
  always @(posedge clk_i) begin
    sorted_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (owed_beats.size() == 0) begin
        note_error($sformatf("unexpected beat value %0d final_res %0b",
                             out_if.sorted_value, out_if.final_res));
      end else begin
        want = owed_beats.pop_front();
        if (out_if.sorted_value !== want.sorted_value)
          note_error($sformatf("sorted_value exp %0d got %0d",
                               want.sorted_value, out_if.sorted_value));
        if (out_if.final_res !== want.final_res)
          note_error($sformatf("final_res exp %0b got %0b (value %0d)",
                               want.final_res, out_if.final_res, want.sorted_value));
      end
    end
  end

  // one batch of extremes, with repeats so equal values sit side by side
  task automatic test_extreme_values();
    logic signed [DATA_W-1:0] vals [BATCH];
    vals = '{ELEM_MAX, ELEM_MIN, 0, -1, 1, ELEM_MAX, ELEM_MIN, 5,
             5, -5, ELEM_MAX - 1, ELEM_MIN + 1, 0, 32'h5555_5555, 32'hAAAA_AAAA, 5};
    for (int i = 0; i < BATCH; i++) send_element(vals[i]);
  endtask

  // a partial batch must give nothing, even after a long quiet spell
  task automatic test_incomplete_batch();
    send_element(ELEM_MIN);
    send_element(3);
    send_element(ELEM_MAX);
    send_element(-3);
    send_element(0);
    drain_results();
    repeat (SORT_LAT + 20) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_element(batch_fill_e shape);
    int signed step;
    step = batch_fill * 1000 + $urandom_range(0, 999);
    case (shape)
      FILL_NARROW: begin
        return $urandom_range(0, 6) - 3;
      end
      FILL_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return ELEM_MIN;
          1:       return ELEM_MIN + 1;
          2:       return ELEM_MAX;
          3:       return ELEM_MAX - 1;
          4:       return 0;
          default: return -1;
        endcase
      end
      FILL_RISING: begin
        return step - 8000;
      end
      FILL_FALLING: begin
        return 8000 - step;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // random batches of varied shape, idling style changed per batch
  task automatic test_random_batches(int unsigned count);
    batch_fill_e shape;
    shape = FILL_ANY;
    for (int unsigned n = 0; n < count; n++) begin
      if (batch_fill == 0) begin
        case ($urandom_range(0, 7))
          0:       shape = FILL_NARROW;
          1:       shape = FILL_EXTREME;
          2:       shape = FILL_RISING;
          3:       shape = FILL_FALLING;
          default: shape = FILL_ANY;
        endcase
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      if (n == count / 2) drain_results();
      send_element(pick_element(shape));
    end
    in_if.valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    batch_fill     = 0;
    mismatch_count = 0;
    send_burst     = 1'b0;
    recv_burst     = 1'b0;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_values();
    test_incomplete_batch();
    test_random_batches(RANDOM_ELEMS);

    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (SORT_LAT + 40) @(posedge clk_i);
    if (owed_beats.size() != 0)
      note_error($sformatf("%0d beats never arrived", owed_beats.size()));

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
